// ----- hw/rtl/stlfd_pkg.sv -----
package stlfd_pkg;

  // file layout of a binary stl stream
  localparam int unsigned CountPos   = 80;
  localparam int unsigned HeaderLen  = 84;
  localparam int unsigned FacetLen   = 50;
  localparam int unsigned CoordStart = 12;
  localparam int unsigned CoordEnd   = 48;

  // 84 + 50 * (2^32 - 1) fits in 39 bits
  localparam int unsigned NeedW = 39;

  // result queue
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  typedef enum logic {
    KIND_COORD  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_SHORT    = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] word;
    logic [31:0] facet;
    logic [1:0]  corner;
    logic [1:0]  axis;
    status_e     status;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } res_push_t;

  // word index 0..8 within the facet -> {corner, axis}
  function automatic logic [3:0] corner_axis(logic [3:0] widx);
    logic [3:0] ca;
    unique case (widx)
      4'd0:    ca = {2'd0, 2'd0};
      4'd1:    ca = {2'd0, 2'd1};
      4'd2:    ca = {2'd0, 2'd2};
      4'd3:    ca = {2'd1, 2'd0};
      4'd4:    ca = {2'd1, 2'd1};
      4'd5:    ca = {2'd1, 2'd2};
      4'd6:    ca = {2'd2, 2'd0};
      4'd7:    ca = {2'd2, 2'd1};
      4'd8:    ca = {2'd2, 2'd2};
      default: ca = 4'd0;
    endcase
    return ca;
  endfunction

endpackage

// ----- hw/rtl/stlfd_if.sv -----
interface stlfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       final_byte;

  modport source (output valid, output byte_in, output final_byte, input ready);
  modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

interface stlfd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] word;
  logic [31:0] facet;
  logic [1:0]  corner;
  logic [1:0]  axis;
  logic [1:0]  status;
  logic        run_end;

  modport source (
    output valid, output kind, output word, output facet, output corner,
    output axis, output status, output run_end, input ready
  );
  modport sink (
    input valid, input kind, input word, input facet, input corner,
    input axis, input status, input run_end, output ready
  );
endinterface

// ----- hw/rtl/stlfd_res_fifo.sv -----
module stlfd_res_fifo
  import stlfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output result_t   data_o
);

  result_t              mem_q [ResDepth];
  logic [ResPtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ResCntW-1:0]   cnt_q, cnt_d;
  logic [ResPtrW-1:0]   wptr_nxt;
  logic                 pop;

  assign valid_o  = (cnt_q != '0);
  assign data_o   = mem_q[rptr_q];
  assign room_o   = (cnt_q <= ResCntW'(ResDepth - 2));
  assign pop      = valid_o && ready_i;
  assign wptr_nxt = wptr_q + 1'b1;

  always_comb begin
    wptr_d = wptr_q + ResPtrW'(push_i.cnt);
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + ResCntW'(push_i.cnt) - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_nxt] <= push_i.second;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> (ResCntW'(ResDepth) - cnt_q) >= ResCntW'(push_i.cnt))
    else $error("result queue overflow");

  a_push_at_most_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd3)
    else $error("more than two results pushed in one cycle");

endmodule

// ----- hw/rtl/binary_stl_facet_deframer.sv -----
// path: a byte is registered at acceptance, decoded once the result queue has room and
//   its results are then written to the result queue, whose head drives the output
// throughput: one byte per cycle while the result queue has room; a final byte that also
//   completes a coordinate makes two results, drained one per cycle while out_o is ready
// reset: asynchronous active-low; counters, count and facet state clear to zero,
//   result queue empties; after each final byte the parser state clears to zero again
module binary_stl_facet_deframer
  import stlfd_pkg::*;
#(
  parameter int unsigned BYTE_COUNT_BITS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stlfd_byte_if.sink  in_i,
  stlfd_res_if.source out_o
);

  // compare width for file length against needed length
  localparam int unsigned CmpW = (BYTE_COUNT_BITS > NeedW) ? BYTE_COUNT_BITS : NeedW;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       final_q;

  // parser state
  logic [BYTE_COUNT_BITS-1:0] bytes_seen_q, bytes_seen_d;
  logic [31:0]                claimed_q, claimed_d;
  logic [23:0]                partial_q, partial_d;
  logic [5:0]                 facet_off_q, facet_off_d;
  logic [31:0]                facet_num_q, facet_num_d;

  logic                       accept_in;
  logic                       consume;
  logic                       room;
  logic [BYTE_COUNT_BITS-1:0] seen_inc;
  logic [5:0]                 rel;
  logic [3:0]                 ca;
  logic                       emit_word;
  logic [NeedW-1:0]           needed;
  logic [CmpW-1:0]            len_x, need_x;
  result_t                    word_res, stat_res, head;
  res_push_t                  push;

  assign accept_in = in_i.valid && in_i.ready;
  // a byte leaves the input register only when the queue can take two results
  assign consume   = in_valid_q && room;
  assign in_i.ready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept_in) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      byte_q  <= in_i.byte_in;
      final_q <= in_i.final_byte;
    end
  end

  // decode one byte
  always_comb begin
    claimed_d   = claimed_q;
    partial_d   = partial_q;
    facet_off_d = facet_off_q;
    facet_num_d = facet_num_q;
    emit_word   = 1'b0;
    rel         = facet_off_q - 6'(CoordStart);
    ca          = corner_axis(rel[5:2]);

    // saturating byte counter
    seen_inc     = (bytes_seen_q == '1) ? bytes_seen_q : bytes_seen_q + 1'b1;
    bytes_seen_d = seen_inc;

    if (bytes_seen_q >= BYTE_COUNT_BITS'(CountPos) &&
        bytes_seen_q <  BYTE_COUNT_BITS'(HeaderLen)) begin
      // count bytes, little-endian; 80 is a multiple of 4 so the low bits give the lane
      claimed_d = claimed_q | (32'(byte_q) << {bytes_seen_q[1:0], 3'b000});
    end else if (bytes_seen_q >= BYTE_COUNT_BITS'(HeaderLen) &&
                 facet_num_q < claimed_q) begin
      if (facet_off_q >= 6'(CoordStart) && facet_off_q < 6'(CoordEnd)) begin
        if (rel[1:0] == 2'd3) begin
          emit_word = 1'b1;
          partial_d = '0;
        end else begin
          partial_d = partial_q | (24'(byte_q) << {rel[1:0], 3'b000});
        end
      end
      if (facet_off_q >= 6'(FacetLen - 1)) begin
        facet_off_d = '0;
        facet_num_d = facet_num_q + 1'b1;
      end else begin
        facet_off_d = facet_off_q + 1'b1;
      end
    end

    // end-of-file status, from the length including this byte
    needed = NeedW'(HeaderLen) + NeedW'(claimed_d) * NeedW'(FacetLen);
    len_x  = CmpW'(seen_inc);
    need_x = CmpW'(needed);

    word_res.kind    = KIND_COORD;
    word_res.word    = {byte_q, partial_q};
    word_res.facet   = facet_num_q;
    word_res.corner  = ca[3:2];
    word_res.axis    = ca[1:0];
    word_res.status  = ST_MATCH;
    word_res.run_end = !final_q;

    stat_res.kind    = KIND_STATUS;
    stat_res.word    = '0;
    stat_res.facet   = claimed_d;
    stat_res.corner  = '0;
    stat_res.axis    = '0;
    stat_res.run_end = 1'b1;
    priority if (len_x < CmpW'(HeaderLen)) begin
      stat_res.status = ST_SHORT;
      stat_res.facet  = '0;
    end else if (len_x == need_x) begin
      stat_res.status = ST_MATCH;
    end else if (claimed_d != '0 && need_x > len_x) begin
      stat_res.status = ST_TRUNC;
    end else begin
      stat_res.status = ST_MISMATCH;
    end

    // final byte: back to reset state for the next file
    if (final_q) begin
      bytes_seen_d = '0;
      claimed_d    = '0;
      partial_d    = '0;
      facet_off_d  = '0;
      facet_num_d  = '0;
    end

    // word goes first when both come from one byte
    push.cnt    = consume ? (2'(emit_word) + 2'(final_q)) : 2'd0;
    push.first  = emit_word ? word_res : stat_res;
    push.second = stat_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      claimed_q    <= '0;
      partial_q    <= '0;
      facet_off_q  <= '0;
      facet_num_q  <= '0;
    end else if (consume) begin
      bytes_seen_q <= bytes_seen_d;
      claimed_q    <= claimed_d;
      partial_q    <= partial_d;
      facet_off_q  <= facet_off_d;
      facet_num_q  <= facet_num_d;
    end
  end

  // result queue, two-entry push, one-entry pop
  stlfd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head)
  );

  assign out_o.kind    = head.kind;
  assign out_o.word    = head.word;
  assign out_o.facet   = head.facet;
  assign out_o.corner  = head.corner;
  assign out_o.axis    = head.axis;
  assign out_o.status  = head.status;
  assign out_o.run_end = head.run_end;

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    facet_off_q < 6'(FacetLen))
    else $error("facet offset out of range");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && final_q |=> bytes_seen_q == '0 && facet_num_q == '0 && claimed_q == '0)
    else $error("state not cleared after final beat");

  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == KIND_STATUS |-> out_o.run_end)
    else $error("status result without run end");

endmodule
